[rtl/palh_pkg.sv]
// Shared types, constants and the arctangent table for the path arc length and heading block.
// No dependencies; every other file imports this package.
package palh_pkg;

	localparam int CORDIC_ITERATIONS = 16;
	localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
	localparam int ITER_W = 5;
	localparam int COORD_W = 32;
	localparam int DIFF_W = COORD_W + 1;
	localparam int PRESCALE = 24;
	localparam int VEC_W = 60;
	localparam int ANG_W = 34;
	localparam int ACC_W = 61;
	localparam int LEN_W = 40;
	localparam int SEG_LEN_W = ACC_W - PRESCALE;
	localparam int HEAD_W = 16;
	localparam int HEAD_RAW_W = ANG_W - 17;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;

	localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);
	localparam logic [31:0] INV_K = 32'(64'd2608131496
		+ ((CORDIC_STEPS < 16) ? (64'd1738754331 >> (2 * CORDIC_STEPS)) : 64'd0));
	localparam logic signed [ANG_W-1:0] HALF_PI_Z = 34'sd1686629713;
	localparam logic signed [ANG_W-1:0] HEAD_RND = 34'sd65536;
	localparam logic signed [HEAD_RAW_W-1:0] HEAD_MAX = 17'sd25736;
	localparam logic signed [HEAD_RAW_W-1:0] HEAD_MIN = -17'sd25736;
	localparam logic [ACC_W-1:0] LEN_RND = ACC_W'(64'd1 << (PRESCALE - 1));
	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	localparam logic [31:0] ATAN_TAB [32] = '{
		32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
		32'd67021687, 32'd33543516, 32'd16775851, 32'd8388437,
		32'd4194283, 32'd2097149, 32'd1048576, 32'd524288,
		32'd262144, 32'd131072, 32'd65536, 32'd32768,
		32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128,
		32'd64, 32'd32, 32'd16, 32'd8,
		32'd4, 32'd2, 32'd1, 32'd0
	};

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic first_point;
		logic last_point;
	} point_t;

	typedef struct packed {
		logic [LEN_W-1:0] arc_length;
		logic signed [HEAD_W-1:0] heading;
		logic end_of_path;
	} result_t;

	typedef enum logic [1:0] {
		PATH_NONE,
		PATH_FIRST,
		PATH_OPEN
	} path_state_t;

	typedef enum logic {
		CMD_SINGLE,
		CMD_SEGMENT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
		logic zero;
		logic first_seg;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROTATE,
		BK_MUL_LO,
		BK_MUL_HI,
		BK_FINISH,
		BK_EMIT_HEAD,
		BK_EMIT_TAIL
	} back_state_t;

endpackage

[rtl/palh_front.sv]
// Front end: accepts path points, tracks the open path and issues segment requests and one-point-path requests.
// Depends on palh_pkg.
module palh_front import palh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         point_valid,
	output logic         point_stall,
	input  point_t       point,
	input  fifo_status_t fifo_status,
	output logic         push,
	output cmd_t         cmd
);

	path_state_t path_q, path_next;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic accept, start;

	assign point_stall = fifo_status.full;
	assign accept = point_valid && !fifo_status.full;
	assign start = point.first_point || (path_q == PATH_NONE);

	always_comb begin
		path_next = path_q;
		if (accept) begin
			if (point.last_point)
				path_next = PATH_NONE;
			else if (start)
				path_next = PATH_FIRST;
			else
				path_next = PATH_OPEN;
		end
	end

	always_comb begin
		push = accept && (!start || point.last_point);
		cmd.kind = start ? CMD_SINGLE : CMD_SEGMENT;
		cmd.dx = DIFF_W'(point.point_x) - DIFF_W'(prev_x_q);
		cmd.dy = DIFF_W'(point.point_y) - DIFF_W'(prev_y_q);
		cmd.zero = (point.point_x == prev_x_q) && (point.point_y == prev_y_q);
		cmd.first_seg = (path_q == PATH_FIRST);
		cmd.last = point.last_point;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_q <= PATH_NONE;
			prev_x_q <= '0;
			prev_y_q <= '0;
		end else if (accept) begin
			path_q <= path_next;
			prev_x_q <= point.point_x;
			prev_y_q <= point.point_y;
		end
	end

endmodule

[rtl/palh_fifo.sv]
// Short request queue between the front end and the CORDIC back end.
// Depends on palh_pkg.
module palh_fifo import palh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  cmd_t         push_cmd,
	input  logic         pop,
	output cmd_t         head_cmd,
	output fifo_status_t status
);

	cmd_t entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0] count_q;

	assign status.full = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign head_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[rtl/palh_back.sv]
// Back end: iterative vectoring CORDIC, gain correction, arc length accumulation, result register.
// Depends on palh_pkg.
module palh_back import palh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  fifo_status_t fifo_status,
	input  cmd_t         head_cmd,
	output logic         pop,
	output logic         result_valid,
	input  logic         result_stall,
	output result_t      result
);

	back_state_t state_q, state_next;
	logic [ITER_W-1:0] iter_q;
	logic signed [VEC_W-1:0] x_q, y_q;
	logic signed [ANG_W-1:0] z_q;
	logic [ACC_W-1:0] acc_q;
	logic [LEN_W-1:0] run_len_q;
	logic signed [HEAD_W-1:0] head_q;
	logic zero_q, first_seg_q, last_q;
	logic out_valid_q;
	result_t out_q;

	logic out_free, load_out;
	result_t out_next;
	logic signed [VEC_W-1:0] x0, y0, x_init, y_init, xs, ys;
	logic signed [ANG_W-1:0] z_init, atan_z;
	logic [31:0] mul_a;
	logic [63:0] prod;
	logic [ACC_W-1:0] acc_rnd;
	logic [SEG_LEN_W-1:0] seg_len;
	logic [LEN_W:0] len_sum;
	logic [LEN_W-1:0] len_new;
	logic signed [ANG_W-1:0] z_rnd;
	logic signed [HEAD_RAW_W-1:0] head_raw;
	logic signed [HEAD_W-1:0] head_new;

	assign out_free = !out_valid_q || !result_stall;
	assign result_valid = out_valid_q;
	assign result = out_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!fifo_status.empty) begin
					if (head_cmd.kind == CMD_SINGLE)
						state_next = BK_EMIT_TAIL;
					else if (head_cmd.zero)
						state_next = BK_FINISH;
					else
						state_next = BK_ROTATE;
				end
			end
			BK_ROTATE: begin
				if (iter_q == LAST_ITER)
					state_next = BK_MUL_LO;
			end
			BK_MUL_LO: state_next = BK_MUL_HI;
			BK_MUL_HI: state_next = BK_FINISH;
			BK_FINISH: state_next = first_seg_q ? BK_EMIT_HEAD : BK_EMIT_TAIL;
			BK_EMIT_HEAD: begin
				if (out_free)
					state_next = BK_EMIT_TAIL;
			end
			BK_EMIT_TAIL: begin
				if (out_free)
					state_next = BK_IDLE;
			end
			default: state_next = BK_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == BK_IDLE) && !fifo_status.empty;
		load_out = ((state_q == BK_EMIT_HEAD) || (state_q == BK_EMIT_TAIL)) && out_free;
		out_next.heading = head_q;
		if (state_q == BK_EMIT_HEAD) begin
			out_next.arc_length = '0;
			out_next.end_of_path = 1'b0;
		end else begin
			out_next.arc_length = run_len_q;
			out_next.end_of_path = last_q;
		end
	end

	// pre-rotate into the right half plane
	always_comb begin
		x0 = {{(VEC_W - DIFF_W - PRESCALE){head_cmd.dx[DIFF_W-1]}}, head_cmd.dx,
			{PRESCALE{1'b0}}};
		y0 = {{(VEC_W - DIFF_W - PRESCALE){head_cmd.dy[DIFF_W-1]}}, head_cmd.dy,
			{PRESCALE{1'b0}}};
		x_init = x0;
		y_init = y0;
		z_init = '0;
		if (x0 < 0) begin
			if (y0 >= 0) begin
				x_init = y0;
				y_init = -x0;
				z_init = HALF_PI_Z;
			end else begin
				x_init = -y0;
				y_init = x0;
				z_init = -HALF_PI_Z;
			end
		end
	end

	always_comb begin
		xs = x_q >>> iter_q;
		ys = y_q >>> iter_q;
		atan_z = ANG_W'(ATAN_TAB[iter_q]);
		mul_a = (state_q == BK_MUL_LO) ? x_q[31:0] : 32'(x_q[VEC_W-1:32]);
		prod = 64'(mul_a) * 64'(INV_K);
		acc_rnd = acc_q + LEN_RND;
		seg_len = zero_q ? '0 : acc_rnd[ACC_W-1:PRESCALE];
		len_sum = {1'b0, run_len_q} + (LEN_W+1)'(seg_len);
		if (first_seg_q)
			len_new = LEN_W'(seg_len);
		else if (len_sum[LEN_W])
			len_new = LEN_MAX;
		else
			len_new = len_sum[LEN_W-1:0];
		z_rnd = z_q + HEAD_RND;
		head_raw = HEAD_RAW_W'(z_rnd >>> 17);
		if (zero_q)
			head_new = '0;
		else if (head_raw > HEAD_MAX)
			head_new = HEAD_W'(HEAD_MAX);
		else if (head_raw < HEAD_MIN)
			head_new = HEAD_W'(HEAD_MIN);
		else
			head_new = HEAD_W'(head_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			out_valid_q <= 1'b0;
			run_len_q <= '0;
		end else begin
			state_q <= state_next;
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!result_stall)
				out_valid_q <= 1'b0;
			if (pop && (head_cmd.kind == CMD_SINGLE))
				run_len_q <= '0;
			else if (state_q == BK_FINISH)
				run_len_q <= len_new;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_q <= out_next;
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					x_q <= x_init;
					y_q <= y_init;
					z_q <= z_init;
					iter_q <= '0;
					zero_q <= head_cmd.zero;
					first_seg_q <= (head_cmd.kind == CMD_SINGLE) ? 1'b0 : head_cmd.first_seg;
					last_q <= (head_cmd.kind == CMD_SINGLE) ? 1'b1 : head_cmd.last;
					if (head_cmd.kind == CMD_SINGLE)
						head_q <= '0;
				end
			end
			BK_ROTATE: begin
				iter_q <= iter_q + 1'b1;
				if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + atan_z;
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - atan_z;
				end
			end
			BK_MUL_LO: acc_q <= ACC_W'(prod >> 32);
			BK_MUL_HI: acc_q <= acc_q + ACC_W'(prod);
			BK_FINISH: head_q <= head_new;
			BK_EMIT_HEAD, BK_EMIT_TAIL: ;
			default: ;
		endcase
	end

endmodule

[rtl/path_arc_length_heading.sv]
// Top level of the path arc length and heading block.
// Depends on palh_pkg, palh_front, palh_fifo and palh_back.
//
// Usage:
// Points of a path enter on the point channel (valid/stall), one Q16.16 x,y
// pair per request, flagged first_point and last_point. Results leave on the
// result channel as arc length (Q24.16, saturating) and heading (Q2.13 rad).
// The first point of a path produces no result on its own; the second point
// produces two results, the held first one and its own. A point flagged both
// first and last yields one result with length 0 and heading 0.
// A segment point passes through the iterative CORDIC rotation, the gain
// multiply (low half, then high half) and a finish step before its result;
// a zero-length segment skips the rotation and multiply, and a one-point
// path result skips all three. The back end takes no new request until its
// results are out; the second point of a path emits one more. A four-entry
// request queue lets the front accept points meanwhile.
// point_stall rises only when that queue is full.
// Reset clears the open path, the running length, the queue and the result
// valid flag. While result_stall holds a valid result, the back end waits to
// emit the next; the queue then fills and stalls the point channel.
module path_arc_length_heading import palh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    point_valid,
	output logic    point_stall,
	input  point_t  point,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	fifo_status_t fifo_status;
	logic push, pop;
	cmd_t push_cmd, head_cmd;

	palh_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point),
		.fifo_status (fifo_status),
		.push        (push),
		.cmd         (push_cmd)
	);

	palh_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head_cmd (head_cmd),
		.status   (fifo_status)
	);

	palh_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_status  (fifo_status),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_status.full)
		else $error("request pushed into full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_status.empty)
		else $error("request popped from empty queue");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.heading <= HEAD_W'(HEAD_MAX))
			&& (result.heading >= HEAD_W'(HEAD_MIN)))
		else $error("heading outside clamp range");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		point_stall |-> fifo_status.full)
		else $error("point channel stalled with queue space");

endmodule
